### rtl/core/msadpcm_pkg.sv
// Shared types, constants and tables for the MS ADPCM block decoder.
// No dependencies.
package msadpcm_pkg;

    localparam int SPB_RESET = 2036;
    localparam int STEP_MIN  = 16;

    localparam logic [0:0] CFG_STEREO = 1'b0;
    localparam logic [0:0] CFG_SPB    = 1'b1;

    // request from sequencer to the nibble unit
    typedef struct packed {
        logic               start;
        logic [3:0]         code;
        logic signed [31:0] step;
        logic signed [15:0] s1;
        logic signed [15:0] s2;
        logic signed [11:0] c1;
        logic signed [11:0] c2;
    } nib_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] step;
        logic signed [15:0] sample;
    } nib_rsp_t;

    function automatic logic [9:0] adapt_lut(input logic [3:0] c);
        logic [9:0] r;
        begin
            unique case (c)
                4'd4, 4'd12: r = 10'd307;
                4'd5, 4'd11: r = 10'd409;
                4'd6, 4'd10: r = 10'd512;
                4'd7, 4'd9:  r = 10'd614;
                4'd8:        r = 10'd768;
                default:     r = 10'd230;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [11:0] gain1_lut(input logic [7:0] i);
        logic signed [11:0] r;
        begin
            unique case (i)
                8'd0:    r = 12'sd256;
                8'd1:    r = 12'sd512;
                8'd2:    r = 12'sd0;
                8'd3:    r = 12'sd192;
                8'd4:    r = 12'sd240;
                8'd5:    r = 12'sd460;
                default: r = 12'sd392;
            endcase
            return r;
        end
    endfunction

    // indexes above 6 take the last pair
    function automatic logic signed [11:0] gain2_lut(input logic [7:0] i);
        logic signed [11:0] r;
        begin
            unique case (i)
                8'd0, 8'd2, 8'd4: r = 12'sd0;
                8'd1:    r = -12'sd256;
                8'd3:    r = 12'sd64;
                8'd5:    r = -12'sd208;
                default: r = -12'sd232;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/core/ms_adpcm_block_decoder.sv
// Top level of the MS ADPCM block decoder: header parse, sequencer, output queue.
// Depends on msadpcm_pkg and msadpcm_nibble.
//
// Usage:
//   s_axis_* carries one compressed byte per item. m_axis_* returns decoded
//   samples: tdata = pcm_sample, tuser = {block_end, channel}.
//   cfg_* writes stereo_mode (index 0) or samples_per_block (index 1); the
//   user is to write only while idle, as the block does not enforce it.
//   A header byte other than the last leaves the block ready for the next
//   byte. The last header byte queues 2 (mono) or 4 (stereo) samples, and the
//   next byte is taken once all of them have gone out. A data byte runs its
//   high and then its low nibble through the shared multiplier unit, the low
//   one started once the high one is done (a lone high nibble at the end of an
//   odd mono block runs alone); its results go out once the last is done.
//   Results go out one per cycle when m_axis_tready is high.
//   s_axis_tready stays low until all results of the previous byte are taken,
//   so a stalled receiver holds the input side.
//   Reset returns to expecting the first header byte, mono, 2036 samples.
module ms_adpcm_block_decoder
    import msadpcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pcm_sample
    output logic [1:0]  m_axis_tuser,   // [0] channel, [1] block_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_HI   = 2'd1;
    localparam logic [1:0] SQ_LO   = 2'd2;
    localparam logic [1:0] SQ_OUT  = 2'd3;

    logic        stereo_reg;
    logic [15:0] spb_reg;

    logic signed [11:0] c1_reg [2];
    logic signed [11:0] c2_reg [2];
    logic signed [31:0] step_reg [2];
    logic signed [15:0] s1_reg [2];
    logic signed [15:0] s2_reg [2];
    logic [3:0]  hidx_reg;
    logic        inhdr_reg;
    logic [15:0] left_reg;
    logic [7:0]  hold_reg;

    logic [1:0]  sq_reg;
    logic [7:0]  byte_reg;
    logic        lo_en_reg;
    logic        lo_ch_reg;
    logic        lo_go_reg;

    // output queue of up to four items
    logic [17:0] q_reg [4];
    logic [2:0]  qcnt_reg;
    logic [1:0]  qrd_reg;

    nib_req_t req;
    nib_rsp_t rsp;

    msadpcm_nibble u_nib (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (sq_reg == SQ_IDLE) && (qcnt_reg == 3'd0);
    assign m_axis_tvalid = (sq_reg == SQ_OUT) && (qcnt_reg != 3'd0);
    assign m_axis_tdata  = q_reg[qrd_reg][15:0];
    assign m_axis_tuser  = q_reg[qrd_reg][17:16];

    logic        acc_in;
    logic [3:0]  last;
    logic [3:0]  idx;
    logic signed [15:0] wd;
    logic [15:0] nleft;
    logic        cur_ch;

    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign last   = stereo_reg ? 4'd13 : 4'd6;
    assign idx    = (hidx_reg > last) ? last : hidx_reg;
    assign wd     = $signed({s_axis_tdata, hold_reg});
    assign nleft  = (spb_reg > 16'd2) ? spb_reg - 16'd2 : 16'd0;
    assign cur_ch = (sq_reg == SQ_LO) ? lo_ch_reg : 1'b0;

    always_comb
    begin
        req.start = lo_go_reg;
        req.code  = (sq_reg == SQ_LO) ? byte_reg[3:0] : byte_reg[7:4];
        req.step  = step_reg[cur_ch];
        req.s1    = s1_reg[cur_ch];
        req.s2    = s2_reg[cur_ch];
        req.c1    = c1_reg[cur_ch];
        req.c2    = c2_reg[cur_ch];
        if (acc_in && !inhdr_reg)
        begin
            req.start = 1'b1;
            req.code  = s_axis_tdata[7:4];
            req.step  = step_reg[0];
            req.s1    = s1_reg[0];
            req.s2    = s2_reg[0];
            req.c1    = c1_reg[0];
            req.c2    = c2_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg <= 1'b0;
            spb_reg    <= 16'(SPB_RESET);
            hidx_reg   <= 4'd0;
            inhdr_reg  <= 1'b1;
            left_reg   <= 16'd0;
            hold_reg   <= 8'd0;
            sq_reg     <= SQ_IDLE;
            byte_reg   <= 8'd0;
            qcnt_reg   <= 3'd0;
            qrd_reg    <= 2'd0;
            lo_en_reg  <= 1'b0;
            lo_ch_reg  <= 1'b0;
            for (int c = 0; c < 2; c++)
            begin
                c1_reg[c]   <= '0;
                c2_reg[c]   <= '0;
                step_reg[c] <= '0;
                s1_reg[c]   <= '0;
                s2_reg[c]   <= '0;
            end
            for (int k = 0; k < 4; k++)
                q_reg[k] <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_STEREO: stereo_reg <= cfg_data[0];
                    CFG_SPB:    spb_reg    <= cfg_data;
                    default: ;
                endcase
            end
            unique case (sq_reg)
                SQ_IDLE:
                if (acc_in)
                begin
                    byte_reg <= s_axis_tdata;
                    if (inhdr_reg)
                    begin
                        if (idx == 4'd0)
                        begin
                            c1_reg[0] <= gain1_lut(s_axis_tdata);
                            c2_reg[0] <= gain2_lut(s_axis_tdata);
                        end
                        else if (stereo_reg && idx == 4'd1)
                        begin
                            c1_reg[1] <= gain1_lut(s_axis_tdata);
                            c2_reg[1] <= gain2_lut(s_axis_tdata);
                        end
                        else if (idx[0] ^ stereo_reg)
                            hold_reg <= s_axis_tdata;
                        else if (!stereo_reg)
                        begin
                            if (idx == 4'd2) step_reg[0] <= 32'(wd);
                            else if (idx == 4'd4) s1_reg[0] <= wd;
                            else s2_reg[0] <= wd;
                        end
                        else
                        begin
                            // words alternate left, right starting at byte 3
                            if (idx < 4'd6) step_reg[!idx[1]] <= 32'(wd);
                            else if (idx < 4'd10) s1_reg[!idx[1]] <= wd;
                            else s2_reg[!idx[1]] <= wd;
                        end
                        if (idx < last)
                            hidx_reg <= idx + 4'd1;
                        else
                        begin
                            // header done: emit stored samples, older first;
                            // the last byte completes the older word
                            hidx_reg  <= 4'd0;
                            left_reg  <= nleft;
                            inhdr_reg <= (nleft == 16'd0);
                            qrd_reg   <= 2'd0;
                            sq_reg    <= SQ_OUT;
                            if (!stereo_reg)
                            begin
                                q_reg[0] <= {2'b00, wd};
                                q_reg[1] <= {(nleft == 16'd0), 1'b0, s1_reg[0]};
                                qcnt_reg <= 3'd2;
                            end
                            else
                            begin
                                q_reg[0] <= {2'b00, s2_reg[0]};
                                q_reg[1] <= {2'b01, wd};
                                q_reg[2] <= {2'b00, s1_reg[0]};
                                q_reg[3] <= {(nleft == 16'd0), 1'b1, s1_reg[1]};
                                qcnt_reg <= 3'd4;
                            end
                        end
                    end
                    else
                    begin
                        lo_en_reg <= stereo_reg || (left_reg >= 16'd2);
                        lo_ch_reg <= stereo_reg;
                        if (stereo_reg)
                            left_reg <= (left_reg > 16'd0) ? left_reg - 16'd1 : 16'd0;
                        else
                            left_reg <= (left_reg >= 16'd2) ? left_reg - 16'd2 : 16'd0;
                        sq_reg <= SQ_HI;
                    end
                end
                SQ_HI:
                if (rsp.done)
                begin
                    step_reg[0] <= rsp.step;
                    s2_reg[0]   <= s1_reg[0];
                    s1_reg[0]   <= rsp.sample;
                    q_reg[0]    <= {(!lo_en_reg), 1'b0, rsp.sample};
                    qcnt_reg    <= 3'd1;
                    qrd_reg     <= 2'd0;
                    if (lo_en_reg)
                        sq_reg <= SQ_LO;
                    else
                    begin
                        inhdr_reg <= 1'b1;
                        sq_reg    <= SQ_OUT;
                    end
                end
                SQ_LO:
                if (rsp.done)
                begin
                    step_reg[lo_ch_reg] <= rsp.step;
                    s2_reg[lo_ch_reg]   <= s1_reg[lo_ch_reg];
                    s1_reg[lo_ch_reg]   <= rsp.sample;
                    q_reg[1]  <= {(left_reg == 16'd0), lo_ch_reg, rsp.sample};
                    qcnt_reg  <= 3'd2;
                    if (left_reg == 16'd0)
                        inhdr_reg <= 1'b1;
                    sq_reg <= SQ_OUT;
                end
                SQ_OUT:
                if (m_axis_tready && qcnt_reg != 3'd0)
                begin
                    qrd_reg  <= qrd_reg + 2'd1;
                    qcnt_reg <= qcnt_reg - 3'd1;
                    if (qcnt_reg == 3'd1)
                        sq_reg <= SQ_IDLE;
                end
                default: sq_reg <= SQ_IDLE;
            endcase
        end
    end

    // second nibble start: fire once when entering SQ_LO
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lo_go_reg <= 1'b0;
        else
            lo_go_reg <= (sq_reg == SQ_HI) && rsp.done && lo_en_reg;
    end

`ifndef SYNTHESIS
    a_qcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= 3'd4) else $error("queue overflow");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_reg != SQ_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_hdr_out: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_reg == SQ_IDLE && qcnt_reg != 3'd0) |-> 1'b0) else $error("lost items");
`endif

endmodule

### rtl/core/msadpcm_nibble.sv
// Nibble decode unit: one shared signed multiplier, sequenced over four steps.
// Depends on msadpcm_pkg.
module msadpcm_nibble
    import msadpcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  nib_req_t req,
    output nib_rsp_t rsp
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_STEP = 3'd1;
    localparam logic [2:0] ST_P1   = 3'd2;
    localparam logic [2:0] ST_P2   = 3'd3;
    localparam logic [2:0] ST_DIFF = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    nib_req_t           r_reg;
    logic signed [43:0] acc_reg, acc_next;
    logic signed [31:0] nstep_reg, nstep_next;
    logic signed [15:0] samp_reg, samp_next;

    // shared multiplier
    logic signed [32:0] ma;
    logic signed [16:0] mb;
    logic signed [49:0] prod;
    assign prod = ma * mb;

    logic signed [49:0] stp_q;
    logic signed [49:0] val;

    always_comb
    begin
        ma = 33'sd0;
        mb = 17'sd0;
        unique case (state_reg)
            ST_STEP: begin ma = 33'(r_reg.step); mb = 17'($signed({1'b0, adapt_lut(r_reg.code)})); end
            ST_P1:   begin ma = 33'(r_reg.s1); mb = 17'(r_reg.c1); end
            ST_P2:   begin ma = 33'(r_reg.s2); mb = 17'(r_reg.c2); end
            ST_DIFF: begin ma = 33'(r_reg.step); mb = 17'($signed(r_reg.code)); end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        nstep_next = nstep_reg;
        samp_next  = samp_reg;
        stp_q      = prod >>> 8;
        val        = prod + 50'(acc_reg >>> 8);
        unique case (state_reg)
            ST_IDLE: if (req.start) state_next = ST_STEP;
            ST_STEP:
            begin
                if (stp_q < 50'sd16)
                    nstep_next = 32'(STEP_MIN);
                else if (stp_q > 50'sd2147483647)
                    nstep_next = 32'sh7FFFFFFF;
                else
                    nstep_next = 32'(stp_q);
                state_next = ST_P1;
            end
            ST_P1: begin acc_next = 44'(prod); state_next = ST_P2; end
            ST_P2: begin acc_next = acc_reg + 44'(prod); state_next = ST_DIFF; end
            ST_DIFF:
            begin
                if (val > 50'sd32767)
                    samp_next = 16'sh7FFF;
                else if (val < -50'sd32768)
                    samp_next = 16'sh8000;
                else
                    samp_next = 16'(val);
                state_next = ST_DONE;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.start)
            r_reg <= req;
        acc_reg   <= acc_next;
        nstep_reg <= nstep_next;
        samp_reg  <= samp_next;
    end

    assign rsp.done   = (state_reg == ST_DONE);
    assign rsp.step   = nstep_reg;
    assign rsp.sample = samp_reg;

endmodule

### sim/tb_ms_adpcm_block_decoder.sv
// Testbench for ms_adpcm_block_decoder: directed table plus random byte streams,
// every decoded sample checked against an in-bench MS ADPCM decoder model.
// Depends on msadpcm_pkg and the RTL of the block.
module tb_ms_adpcm_block_decoder;
    import msadpcm_pkg::*;

    typedef struct packed {
        logic signed [15:0] pcm;
        logic               chan;
        logic               last_flag;
    } sample_t;

    typedef struct {
        logic [7:0] data;
        logic       has_sample;
        sample_t    sample;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    ms_adpcm_block_decoder u_top (.*);

    // decoder model state
    logic        mdl_stereo;
    logic [15:0] mdl_spb;
    int          mdl_c1 [2];
    int          mdl_c2 [2];
    int          mdl_step [2];
    int          mdl_s1 [2];
    int          mdl_s2 [2];
    int          mdl_hidx;
    logic        mdl_in_hdr;
    int          mdl_left;
    logic [7:0]  mdl_low;

    sample_t     pending_samples[$];
    int          errors;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        checking_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint fdiv256(longint x);
        if (x >= 0)
            return x / 256;
        return -((-x + 255) / 256);
    endfunction

    function automatic int adapt_gain(logic [3:0] c);
        case (c)
            4'd4, 4'd12: return 307;
            4'd5, 4'd11: return 409;
            4'd6, 4'd10: return 512;
            4'd7, 4'd9:  return 614;
            4'd8:        return 768;
            default:     return 230;
        endcase
    endfunction

    task automatic load_gains(int ch, logic [7:0] idx);
        int g1 [7];
        int g2 [7];
        int k;
        g1 = '{256, 512, 0, 192, 240, 460, 392};
        g2 = '{0, -256, 0, 64, 0, -208, -232};
        k = (idx > 6) ? 6 : idx;
        mdl_c1[ch] = g1[k];
        mdl_c2[ch] = g2[k];
    endtask

    function automatic int hdr_word(logic [7:0] hi);
        return int'($signed({hi, mdl_low}));
    endfunction

    task automatic decode_code(int ch, logic [3:0] code, output logic signed [15:0] s);
        longint old_step;
        longint nstep;
        longint val;
        old_step = mdl_step[ch];
        nstep = fdiv256(longint'(adapt_gain(code)) * old_step);
        if (nstep < STEP_MIN)
            nstep = STEP_MIN;
        if (nstep > 64'sd2147483647)
            nstep = 64'sd2147483647;
        mdl_step[ch] = int'(nstep);
        val = longint'($signed(code)) * old_step
              + fdiv256(longint'(mdl_s1[ch]) * mdl_c1[ch] + longint'(mdl_s2[ch]) * mdl_c2[ch]);
        if (val > 32767)
            val = 32767;
        else if (val < -32768)
            val = -32768;
        mdl_s2[ch] = mdl_s1[ch];
        mdl_s1[ch] = int'(val);
        s = val[15:0];
    endtask

    function automatic sample_t mk(int v, logic ch, logic e);
        sample_t r;
        r.pcm = v[15:0];
        r.chan = ch;
        r.last_flag = e;
        return r;
    endfunction

    task automatic predict_byte(logic [7:0] b);
        int idx;
        int last;
        int p;
        logic e;
        logic signed [15:0] sa;
        logic signed [15:0] sb;
        if (mdl_in_hdr)
        begin
            last = mdl_stereo ? 13 : 6;
            idx = (mdl_hidx > last) ? last : mdl_hidx;
            if (!mdl_stereo)
            begin
                if (idx == 0)
                    load_gains(0, b);
                else if (idx % 2 == 1)
                    mdl_low = b;
                else if (idx == 2)
                    mdl_step[0] = hdr_word(b);
                else if (idx == 4)
                    mdl_s1[0] = hdr_word(b);
                else
                    mdl_s2[0] = hdr_word(b);
            end
            else
            begin
                if (idx == 0)
                    load_gains(0, b);
                else if (idx == 1)
                    load_gains(1, b);
                else if (idx % 2 == 0)
                    mdl_low = b;
                else
                begin
                    p = (idx - 2) >> 1;
                    if (p < 2)
                        mdl_step[p & 1] = hdr_word(b);
                    else if (p < 4)
                        mdl_s1[p & 1] = hdr_word(b);
                    else
                        mdl_s2[p & 1] = hdr_word(b);
                end
            end
            if (idx < last)
            begin
                mdl_hidx = idx + 1;
                return;
            end
            mdl_hidx = 0;
            mdl_left = (mdl_spb > 2) ? mdl_spb - 2 : 0;
            e = (mdl_left == 0);
            mdl_in_hdr = e;
            if (!mdl_stereo)
            begin
                pending_samples.push_back(mk(mdl_s2[0], 1'b0, 1'b0));
                pending_samples.push_back(mk(mdl_s1[0], 1'b0, e));
            end
            else
            begin
                pending_samples.push_back(mk(mdl_s2[0], 1'b0, 1'b0));
                pending_samples.push_back(mk(mdl_s2[1], 1'b1, 1'b0));
                pending_samples.push_back(mk(mdl_s1[0], 1'b0, 1'b0));
                pending_samples.push_back(mk(mdl_s1[1], 1'b1, e));
            end
            return;
        end
        if (!mdl_stereo)
        begin
            if (mdl_left >= 2)
            begin
                decode_code(0, b[7:4], sa);
                decode_code(0, b[3:0], sb);
                mdl_left -= 2;
                pending_samples.push_back(mk(sa, 1'b0, 1'b0));
                pending_samples.push_back(mk(sb, 1'b0, mdl_left == 0));
            end
            else
            begin
                // odd count: low nibble dropped
                decode_code(0, b[7:4], sa);
                mdl_left = 0;
                pending_samples.push_back(mk(sa, 1'b0, 1'b1));
            end
        end
        else
        begin
            decode_code(0, b[7:4], sa);
            decode_code(1, b[3:0], sb);
            mdl_left = (mdl_left > 0) ? mdl_left - 1 : 0;
            pending_samples.push_back(mk(sa, 1'b0, 1'b0));
            pending_samples.push_back(mk(sb, 1'b1, mdl_left == 0));
        end
        if (mdl_left == 0)
        begin
            mdl_in_hdr = 1'b1;
            mdl_hidx = 0;
        end
    endtask

    // valid stays up between back-to-back items; drain() drops it
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_byte(b);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_STEREO)
            mdl_stereo = val[0];
        else
            mdl_spb = val;
    endtask

    // receiver side with random stall and checking
    always @(posedge clk)
    begin
        sample_t got;
        sample_t exp_s;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]};
                if (pending_samples.size() == 0)
                begin
                    $error("unexpected sample %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_s = pending_samples.pop_front();
                    if (checking_on)
                    begin
                        if (got.pcm !== exp_s.pcm)
                        begin
                            $error("pcm_sample exp %0d got %0d", exp_s.pcm, got.pcm);
                            errors++;
                        end
                        if (got.chan !== exp_s.chan)
                        begin
                            $error("channel exp %0d got %0d", exp_s.chan, got.chan);
                            errors++;
                        end
                        if (got.last_flag !== exp_s.last_flag)
                        begin
                            $error("block_end exp %0d got %0d", exp_s.last_flag,
                                   got.last_flag);
                            errors++;
                        end
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic random_block(int spb);
        int k;
        int nbytes;
        int hdr_len;
        hdr_len = mdl_stereo ? 14 : 7;
        for (k = 0; k < hdr_len; k++)
        begin
            if (k < (mdl_stereo ? 2 : 1))
                send_byte(8'($urandom_range(9)));
            else
                send_byte(8'($urandom_range(255)));
        end
        nbytes = mdl_stereo ? spb - 2 : (spb - 1) / 2;
        for (k = 0; k < nbytes; k++)
            send_byte(8'($urandom_range(255)));
    endtask

    initial
    begin
        stim_row_t rows[$];
        stim_row_t r;
        int i;
        int phase;
        int spb;
        int sent;
        logic [7:0] hdr0 [7];

        errors = 0;
        tx_idle_pct = 10;
        rx_idle_pct = 72;
        checking_on = 1'b1;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STEREO;
        cfg_data = '0;
        mdl_stereo = 1'b0;
        mdl_spb = 16'(SPB_RESET);
        for (i = 0; i < 2; i++)
        begin
            mdl_c1[i] = 0; mdl_c2[i] = 0; mdl_step[i] = 0; mdl_s1[i] = 0; mdl_s2[i] = 0;
        end
        mdl_hidx = 0;
        mdl_in_hdr = 1'b1;
        mdl_left = 0;
        mdl_low = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 14-sample block: six data bytes close it
        write_reg(CFG_SPB, 16'd14);

        // mono header after reset: idx 255 (clamped), delta 0x8000 (negative),
        // newest 0x7FFF, older 0x8000; samples read straight off the bytes
        hdr0 = '{8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h80};
        for (i = 0; i < 7; i++)
        begin
            r.data = hdr0[i];
            r.has_sample = 1'b0;
            rows.push_back(r);
        end
        rows[6].has_sample = 1'b1;
        rows[6].sample = mk(-32768, 1'b0, 1'b0);
        // data bytes: extremes of the nibbles, checked by the model
        r.has_sample = 1'b0;
        r.data = 8'h00; rows.push_back(r);
        r.data = 8'hFF; rows.push_back(r);
        r.data = 8'h78; rows.push_back(r);
        r.data = 8'h87; rows.push_back(r);
        r.data = 8'hA5; rows.push_back(r);
        r.data = 8'h5A; rows.push_back(r);
        for (i = 0; i < rows.size(); i++)
        begin
            send_byte(rows[i].data);
            if (rows[i].has_sample)
            begin
                // typed-in value must agree with the model's older sample
                if (pending_samples[pending_samples.size() - 2] !== rows[i].sample)
                begin
                    $error("pcm_sample exp %0d got %0d", rows[i].sample.pcm,
                           pending_samples[pending_samples.size() - 2].pcm);
                    errors++;
                end
            end
        end
        drain();
        while (!mdl_in_hdr)
            send_byte(8'($urandom_range(255)));

        // short block, odd mono count, stereo, max coef index variety
        write_reg(CFG_SPB, 16'd2);
        random_block(2);
        write_reg(CFG_SPB, 16'd5);
        random_block(5);
        write_reg(CFG_STEREO, 16'd1);
        write_reg(CFG_SPB, 16'd2);
        random_block(2);
        write_reg(CFG_SPB, 16'd14);
        // large deltas, then repeated code 8 drives the step into saturation
        for (i = 0; i < 14; i++)
            send_byte((i == 3 || i == 5) ? 8'h7F :
                      (i < 2 ? 8'd6 : 8'($urandom_range(255))));
        for (i = 0; i < 2; i++)
            send_byte(8'h77);
        for (i = 0; i < 10; i++)
            send_byte(8'h88);
        drain();

        sent = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 10 : (phase == 1 ? 72 : 0);
            rx_idle_pct = (phase == 0) ? 72 : (phase == 1 ? 10 : 0);
            repeat (3)
            begin
                write_reg(CFG_STEREO, 16'($urandom_range(1)));
                spb = ($urandom_range(9) == 0) ? $urandom_range(2, 3) : $urandom_range(2, 12);
                write_reg(CFG_SPB, 16'(spb));
                random_block(spb);
                random_block(spb);
            end
        end
        // largest count register value written once, then a short block
        write_reg(CFG_SPB, 16'hFFFF);
        write_reg(CFG_SPB, 16'd3);
        write_reg(CFG_STEREO, 16'd0);
        random_block(3);
        drain();

        if (errors == 0 && pending_samples.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
